// ===== rtl/core/union_find_connectivity_assert.svh =====
// assertion macros for the union-find connectivity engine
// used by files that carry concurrent checks; no other dependencies
`ifndef UNION_FIND_CONNECTIVITY_ASSERT_SVH
`define UNION_FIND_CONNECTIVITY_ASSERT_SVH

// condition holds at every edge outside reset
`define UFC_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define UFC_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/ufc_pkg.sv =====
// shared types and constants for the union-find connectivity engine
// no dependencies
`timescale 1ns / 1ps

package ufc_pkg;

   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int FIELD_W          = 11;
   localparam int SIZE_W           = 11;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_COMP,
      ST_LINK,
      ST_GROW,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic               connected;
      logic               merged;
      logic [FIELD_W-1:0] set_count;
      logic               bad_index;
   } rsp_type;

endpackage

// ===== rtl/core/ufc_mem.sv =====
// single-port-write, single-port-read table of parent and tree size entries
// registered read data; depends on nothing
`timescale 1ns / 1ps

module ufc_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 21
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ufc_ctrl.sv =====
// sequencer for find with path compression and union by size
// depends on ufc_pkg and union_find_connectivity_assert.svh; drives ufc_mem
`timescale 1ns / 1ps
`include "union_find_connectivity_assert.svh"

module ufc_ctrl import ufc_pkg::*; #(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int SLOT_W       = 10,
   parameter int CNT_W        = 11,
   parameter int ENTRY_W      = 21
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [FIELD_W-1:0] req_element_a,
   input  logic [FIELD_W-1:0] req_element_b,
   output logic               fin_valid,
   input  logic               fin_ready,
   output rsp_type            fin_rsp,
   output logic               mem_wr_en,
   output logic [SLOT_W-1:0]  mem_wr_addr,
   output logic [ENTRY_W-1:0] mem_wr_data,
   output logic [SLOT_W-1:0]  mem_rd_addr,
   input  logic [ENTRY_W-1:0] mem_rd_data
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ELEMENTS - 1);
   localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_ELEMENTS);

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic [CNT_W-1:0]   element_count_ff, element_count_in;
   logic [CNT_W-1:0]   sets_left_ff, sets_left_in;
   logic               phase_ff, phase_in;
   logic               kind_ff, kind_in;
   logic               bad_ff, bad_in;
   logic               conn_ff, conn_in;
   logic               merged_ff, merged_in;
   logic [SLOT_W-1:0]  b_slot_ff, b_slot_in;
   logic [SLOT_W-1:0]  r_ff, r_in;
   logic [SLOT_W-1:0]  start_ff, start_in;
   logic [SLOT_W-1:0]  root_ff, root_in;
   logic [SIZE_W-1:0]  root_sz_ff, root_sz_in;
   logic [SLOT_W-1:0]  ra_ff, ra_in;
   logic [SIZE_W-1:0]  sza_ff, sza_in;
   logic [SLOT_W-1:0]  rb_ff, rb_in;
   logic [SIZE_W-1:0]  szb_ff, szb_in;
   logic [SLOT_W-1:0]  big_ff, big_in;
   logic [SIZE_W-1:0]  grow_sz_ff, grow_sz_in;

   logic [SLOT_W-1:0]  rd_parent;
   logic [SIZE_W-1:0]  rd_size;
   logic [SLOT_W-1:0]  a_slot, b_slot;
   logic               req_bad;
   logic [CNT_W-1:0]   csr_count;
   logic [SLOT_W-1:0]  cmp_lhs, cmp_rhs;
   logic               cmp_eq;

   assign rd_parent = mem_rd_data[SLOT_W-1:0];
   assign rd_size   = mem_rd_data[ENTRY_W-1:SLOT_W];
   assign a_slot    = SLOT_W'(req_element_a - FIELD_W'(1));
   assign b_slot    = SLOT_W'(req_element_b - FIELD_W'(1));

   assign req_bad = (req_element_a == '0) || (req_element_b == '0) ||
                    (CNT_W'(req_element_a) > element_count_ff) ||
                    (CNT_W'(req_element_b) > element_count_ff);

   always_comb begin
      if (csr_wr_data == '0) begin
         csr_count = CNT_W'(1);
      end else if (CNT_W'(csr_wr_data) > MAX_COUNT) begin
         csr_count = MAX_COUNT;
      end else begin
         csr_count = CNT_W'(csr_wr_data);
      end
   end

   // shared slot comparator
   always_comb begin
      case (state_ff)
         ST_LINK: begin
            cmp_lhs = ra_ff;
            cmp_rhs = rb_ff;
         end
         ST_COMP: begin
            cmp_lhs = rd_parent;
            cmp_rhs = root_ff;
         end
         default: begin
            cmp_lhs = rd_parent;
            cmp_rhs = r_ff;
         end
      endcase
   end

   assign cmp_eq = (cmp_lhs == cmp_rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         element_count_ff <= MAX_COUNT;
         sets_left_ff     <= MAX_COUNT;
         phase_ff         <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         element_count_ff <= element_count_in;
         sets_left_ff     <= sets_left_in;
         phase_ff         <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      bad_ff     <= bad_in;
      conn_ff    <= conn_in;
      merged_ff  <= merged_in;
      b_slot_ff  <= b_slot_in;
      r_ff       <= r_in;
      start_ff   <= start_in;
      root_ff    <= root_in;
      root_sz_ff <= root_sz_in;
      ra_ff      <= ra_in;
      sza_ff     <= sza_in;
      rb_ff      <= rb_in;
      szb_ff     <= szb_in;
      big_ff     <= big_in;
      grow_sz_ff <= grow_sz_in;
   end

   always_comb begin
      logic              find_done;
      logic [SLOT_W-1:0] fin_root;
      logic [SIZE_W-1:0] fin_sz;
      logic [SLOT_W-1:0] big;
      logic [SLOT_W-1:0] small_root;
      logic [SIZE_W-1:0] sz_small;

      state_in         = state_ff;
      clr_in           = clr_ff;
      element_count_in = element_count_ff;
      sets_left_in     = sets_left_ff;
      phase_in         = phase_ff;
      kind_in          = kind_ff;
      bad_in           = bad_ff;
      conn_in          = conn_ff;
      merged_in        = merged_ff;
      b_slot_in        = b_slot_ff;
      r_in             = r_ff;
      start_in         = start_ff;
      root_in          = root_ff;
      root_sz_in       = root_sz_ff;
      ra_in            = ra_ff;
      sza_in           = sza_ff;
      rb_in            = rb_ff;
      szb_in           = szb_ff;
      big_in           = big_ff;
      grow_sz_in       = grow_sz_ff;

      req_ready   = 1'b0;
      fin_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = r_ff;
      mem_wr_data = {rd_size, root_ff};
      mem_rd_addr = r_ff;

      find_done  = 1'b0;
      fin_root   = r_ff;
      fin_sz     = rd_size;
      big        = ra_ff;
      small_root = rb_ff;
      sz_small   = szb_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = {SIZE_W'(1), clr_ff};
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SLOT_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = !csr_wr_en;
            if (req_valid && !csr_wr_en) begin
               kind_in     = req_kind;
               bad_in      = req_bad;
               conn_in     = 1'b0;
               merged_in   = 1'b0;
               phase_in    = 1'b0;
               b_slot_in   = b_slot;
               r_in        = a_slot;
               start_in    = a_slot;
               mem_rd_addr = a_slot;
               state_in    = req_bad ? ST_FIN : ST_WALK;
            end
         end
         ST_WALK: begin
            // follow parent links until an entry points at itself
            if (cmp_eq) begin
               root_in    = r_ff;
               root_sz_in = rd_size;
               if (start_ff == r_ff) begin
                  find_done = 1'b1;
                  fin_root  = r_ff;
                  fin_sz    = rd_size;
               end else begin
                  r_in        = start_ff;
                  mem_rd_addr = start_ff;
                  state_in    = ST_COMP;
               end
            end else begin
               r_in        = rd_parent;
               mem_rd_addr = rd_parent;
            end
         end
         ST_COMP: begin
            // repoint each visited entry at the root
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_ff;
            mem_wr_data = {rd_size, root_ff};
            if (cmp_eq) begin
               find_done = 1'b1;
               fin_root  = root_ff;
               fin_sz    = root_sz_ff;
            end else begin
               r_in        = rd_parent;
               mem_rd_addr = rd_parent;
            end
         end
         ST_LINK: begin
            conn_in = cmp_eq;
            if (!kind_ff && !cmp_eq) begin
               if (sza_ff < szb_ff) begin
                  big        = rb_ff;
                  small_root = ra_ff;
                  sz_small   = sza_ff;
               end
               mem_wr_en   = 1'b1;
               mem_wr_addr = small_root;
               mem_wr_data = {sz_small, big};
               big_in      = big;
               grow_sz_in  = SIZE_W'(sza_ff + szb_ff);
               merged_in   = 1'b1;
               if (sets_left_ff != '0) begin
                  sets_left_in = sets_left_ff - CNT_W'(1);
               end
               state_in = ST_GROW;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_GROW: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = big_ff;
            mem_wr_data = {grow_sz_ff, big_ff};
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            fin_valid = 1'b1;
            if (fin_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (find_done) begin
         if (phase_ff == 1'b0) begin
            ra_in       = fin_root;
            sza_in      = fin_sz;
            phase_in    = 1'b1;
            r_in        = b_slot_ff;
            start_in    = b_slot_ff;
            mem_rd_addr = b_slot_ff;
            state_in    = ST_WALK;
         end else begin
            rb_in    = fin_root;
            szb_in   = fin_sz;
            state_in = ST_LINK;
         end
      end

      // register write restarts the set table
      if (csr_wr_en) begin
         element_count_in = csr_count;
         sets_left_in     = csr_count;
         clr_in           = '0;
         state_in         = ST_CLEAR;
      end
   end

   assign fin_rsp.connected = conn_ff;
   assign fin_rsp.merged    = merged_ff;
   assign fin_rsp.set_count = sets_left_ff[FIELD_W-1:0];
   assign fin_rsp.bad_index = bad_ff;

   `UFC_ASSERT_IMPLY(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !mem_wr_en, "table written while idle")
   `UFC_ASSERT_ALWAYS(a_sets_bounded, clock, reset, sets_left_ff <= element_count_ff, "set count above element count")
   `UFC_ASSERT_IMPLY(a_merge_distinct, clock, reset, fin_valid && fin_rsp.merged, !fin_rsp.connected && !fin_rsp.bad_index, "merge reported with shared root or bad index")

endmodule

// ===== rtl/core/union_find_connectivity.sv =====
// channel   | ports                                        | direction
// req       | req_valid req_ready req_kind req_element_a/b | in
// rsp       | rsp_valid rsp_ready rsp_connected rsp_merged | out
//           | rsp_set_count rsp_bad_index                  |
// csr       | csr_wr_en csr_wr_data                        | in
// after reset and after each csr write a clear pass over all MAX_ELEMENTS table entries runs, no item taken
// out-of-range item: goes from accept straight to the finish state and then the result register
// other items: for each of the two finds a walk to the root and a compress pass over the visited nodes,
// then link, a size update on a merge, finish and the result register; one table read per cycle sets the walk rate
// the block returns to idle after each item before the next accept
// the result register lets the next item enter while a result waits on rsp_ready
// top level of the union-find connectivity engine; depends on ufc_pkg, ufc_ctrl, ufc_mem
`timescale 1ns / 1ps

module union_find_connectivity import ufc_pkg::*; #(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [FIELD_W-1:0] req_element_a,
   input  logic [FIELD_W-1:0] req_element_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_connected,
   output logic               rsp_merged,
   output logic [FIELD_W-1:0] rsp_set_count,
   output logic               rsp_bad_index
);

   localparam int SLOT_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W   = ($clog2(MAX_ELEMENTS + 1) > FIELD_W) ?
                            $clog2(MAX_ELEMENTS + 1) : FIELD_W;
   localparam int ENTRY_W = SIZE_W + SLOT_W;

   logic               fin_valid;
   logic               fin_ready;
   rsp_type            fin_rsp;
   logic               mem_wr_en;
   logic [SLOT_W-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic [SLOT_W-1:0]  mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   ufc_ctrl #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .SLOT_W       (SLOT_W),
      .CNT_W        (CNT_W),
      .ENTRY_W      (ENTRY_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_element_a (req_element_a),
      .req_element_b (req_element_b),
      .fin_valid     (fin_valid),
      .fin_ready     (fin_ready),
      .fin_rsp       (fin_rsp),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   ufc_mem #(
      .DEPTH  (MAX_ELEMENTS),
      .ADDR_W (SLOT_W),
      .DATA_W (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // result register
   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_valid && fin_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_connected = rsp_data_ff.connected;
   assign rsp_merged    = rsp_data_ff.merged;
   assign rsp_set_count = rsp_data_ff.set_count;
   assign rsp_bad_index = rsp_data_ff.bad_index;

endmodule

// ===== dv/union_find_connectivity_tb_pkg.sv =====
`timescale 1ns / 1ps
// item kind codes shared by the union-find connectivity testbench files
// no dependencies

package union_find_connectivity_tb_pkg;

   localparam logic KIND_UNITE = 1'b0;
   localparam logic KIND_CHECK = 1'b1;

endpackage

// ===== dv/union_find_connectivity_predictor.sv =====
`timescale 1ns / 1ps
// watches the csr, req and rsp channels, keeps its own disjoint-set table and compares
// every result; depends on ufc_pkg and union_find_connectivity_tb_pkg

module union_find_connectivity_predictor
   import ufc_pkg::*, union_find_connectivity_tb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_kind,
   input  logic [FIELD_W-1:0] req_element_a,
   input  logic [FIELD_W-1:0] req_element_b,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_connected,
   input  logic               rsp_merged,
   input  logic [FIELD_W-1:0] rsp_set_count,
   input  logic               rsp_bad_index,
   output int                 failures,
   output int                 outstanding
);

   localparam int SLOT_W = $clog2(DEF_MAX_ELEMENTS);

   logic [SLOT_W-1:0]  link_of [DEF_MAX_ELEMENTS];
   logic [SIZE_W-1:0]  group_size [DEF_MAX_ELEMENTS];
   logic [FIELD_W-1:0] span;
   logic [FIELD_W-1:0] group_count;
   rsp_type            expected_q [$];

   function automatic void clear_sets(input int value);
      int v;
      v = value;
      if (v < 1) v = 1;
      if (v > DEF_MAX_ELEMENTS) v = DEF_MAX_ELEMENTS;
      span = FIELD_W'(v);
      for (int i = 0; i < DEF_MAX_ELEMENTS; i++) begin
         link_of[i] = SLOT_W'(i);
         group_size[i] = SIZE_W'(1);
      end
      group_count = span;
   endfunction

   // walk to the root, then point every visited slot straight at it
   function automatic logic [SLOT_W-1:0] trace_root(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] r;
      logic [SLOT_W-1:0] cur;
      logic [SLOT_W-1:0] nxt;
      int steps;
      r = slot;
      steps = 0;
      while (steps < DEF_MAX_ELEMENTS && link_of[r] != r) begin
         r = link_of[r];
         steps++;
      end
      cur = slot;
      steps = 0;
      while (steps < DEF_MAX_ELEMENTS && cur != r) begin
         nxt = link_of[cur];
         link_of[cur] = r;
         cur = nxt;
         steps++;
      end
      return r;
   endfunction

   function automatic rsp_type apply_request(input logic kind, input logic [FIELD_W-1:0] a,
                                             input logic [FIELD_W-1:0] b);
      rsp_type res;
      logic [FIELD_W-1:0] sa;
      logic [FIELD_W-1:0] sb;
      logic [SLOT_W-1:0] ra;
      logic [SLOT_W-1:0] rb;
      logic [SLOT_W-1:0] t;
      res = '0;
      if (a == 0 || b == 0 || a > span || b > span) begin
         res.bad_index = 1'b1;
      end else begin
         sa = a - 1'b1;
         sb = b - 1'b1;
         ra = trace_root(sa[SLOT_W-1:0]);
         rb = trace_root(sb[SLOT_W-1:0]);
         res.connected = (ra == rb);
         if (kind == KIND_UNITE && ra != rb) begin
            // smaller tree goes under the larger, ties under element_a
            if (group_size[ra] < group_size[rb]) begin
               t = ra;
               ra = rb;
               rb = t;
            end
            group_size[ra] = group_size[ra] + group_size[rb];
            link_of[rb] = ra;
            if (group_count > 0) group_count = group_count - 1'b1;
            res.merged = 1'b1;
         end
      end
      res.set_count = group_count;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_sets(DEF_MAX_ELEMENTS);
         expected_q.delete();
         failures = 0;
      end else begin
         if (csr_wr_en) clear_sets(int'(csr_wr_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result with no item pending");
               failures++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_connected !== want.connected) begin
                  $error("connected: expected %0d, got %0d", want.connected, rsp_connected);
                  failures++;
               end
               if (rsp_merged !== want.merged) begin
                  $error("merged: expected %0d, got %0d", want.merged, rsp_merged);
                  failures++;
               end
               if (rsp_set_count !== want.set_count) begin
                  $error("set_count: expected %0d, got %0d", want.set_count, rsp_set_count);
                  failures++;
               end
               if (rsp_bad_index !== want.bad_index) begin
                  $error("bad_index: expected %0d, got %0d", want.bad_index, rsp_bad_index);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(apply_request(req_kind, req_element_a, req_element_b));
      end
      outstanding = expected_q.size();
   end

endmodule

// ===== dv/union_find_connectivity_test.sv =====
`timescale 1ns / 1ps
// top of the union-find connectivity testbench: clock, reset, csr writes, item stimulus
// and rsp back-pressure; depends on the block, both packages and the predictor module

module union_find_connectivity_test;
   import ufc_pkg::*;
   import union_find_connectivity_tb_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [FIELD_W-1:0] csr_wr_data;
   logic               req_valid;
   logic               req_ready;
   logic               req_kind;
   logic [FIELD_W-1:0] req_element_a;
   logic [FIELD_W-1:0] req_element_b;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_connected;
   logic               rsp_merged;
   logic [FIELD_W-1:0] rsp_set_count;
   logic               rsp_bad_index;
   int                 failures;
   int                 outstanding;
   int                 sent = 0;

   int csr_plan [10] = '{0, 2047, 2, 5, 16, 1024, 1, 64, 300, 33};

   always #10 clock = ~clock;

   union_find_connectivity DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_element_a (req_element_a),
      .req_element_b (req_element_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_connected (rsp_connected),
      .rsp_merged    (rsp_merged),
      .rsp_set_count (rsp_set_count),
      .rsp_bad_index (rsp_bad_index)
   );

   union_find_connectivity_predictor u_predictor (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_element_a (req_element_a),
      .req_element_b (req_element_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_connected (rsp_connected),
      .rsp_merged    (rsp_merged),
      .rsp_set_count (rsp_set_count),
      .rsp_bad_index (rsp_bad_index),
      .failures      (failures),
      .outstanding   (outstanding)
   );

   task automatic offer(input logic kind, input logic [FIELD_W-1:0] a,
                        input logic [FIELD_W-1:0] b);
      // no sender gaps in the calm stretch
      while (!(sent >= 300 && sent < 450) && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_element_a <= a;
      req_element_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] pick_element(input int n, input int base, input int w);
      logic [FIELD_W-1:0] v;
      case ($urandom_range(19))
         0: v = '0;
         1: v = FIELD_W'(n + 1);
         2: v = FIELD_W'($urandom_range(2047));
         default: v = FIELD_W'(base + $urandom_range(w - 1));
      endcase
      return v;
   endfunction

   // receiver: random stalls, one long hold-off, one calm stretch
   initial begin
      int got;
      int hold;
      bit held;
      got = 0;
      hold = 0;
      held = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) got++;
         if (got == 200 && !held) begin
            held = 1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (got >= 600 && got < 750) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 11);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int n;
      int items;
      int base;
      int w;
      logic kind;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_kind <= KIND_UNITE;
      req_element_a <= '0;
      req_element_b <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset width of 1024 elements
      offer(KIND_UNITE, 0, 5);
      offer(KIND_CHECK, 5, 0);
      offer(KIND_UNITE, 1025, 1);
      offer(KIND_CHECK, 2047, 2047);
      offer(KIND_UNITE, 1, 2);
      offer(KIND_UNITE, 3, 4);
      offer(KIND_UNITE, 1, 3);
      offer(KIND_CHECK, 2, 4);
      offer(KIND_UNITE, 4, 2);
      offer(KIND_UNITE, 5, 1);
      offer(KIND_UNITE, 1024, 1023);
      offer(KIND_UNITE, 1023, 1);
      offer(KIND_CHECK, 1024, 2);
      offer(KIND_CHECK, 1, 1);
      offer(KIND_UNITE, 1, 1);
      offer(KIND_CHECK, 6, 7);
      offer(KIND_UNITE, 1024, 1024);
      offer(KIND_CHECK, 1024, 1025);

      for (int p = 0; p < 10; p++) begin
         req_valid <= 1'b0;
         drain();
         csr_wr_en <= 1'b1;
         csr_wr_data <= FIELD_W'(csr_plan[p]);
         @(posedge clock);
         csr_wr_en <= 1'b0;
         n = csr_plan[p];
         if (n < 1) n = 1;
         if (n > DEF_MAX_ELEMENTS) n = DEF_MAX_ELEMENTS;
         items = (n == 1) ? 40 : 100;
         for (int i = 0; i < items; i++) begin
            // half the items stay in a narrow window so trees grow deep
            if ($urandom_range(1) == 0) begin
               base = 1;
               w = n;
            end else begin
               w = (n < 24) ? n : 24;
               base = 1 + $urandom_range(n - w);
            end
            kind = ($urandom_range(99) < 60) ? KIND_UNITE : KIND_CHECK;
            offer(kind, pick_element(n, base, w), pick_element(n, base, w));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ufc_pkg.sv
rtl/core/ufc_mem.sv
rtl/core/ufc_ctrl.sv
rtl/core/union_find_connectivity.sv
dv/union_find_connectivity_tb_pkg.sv
dv/union_find_connectivity_predictor.sv
dv/union_find_connectivity_test.sv
